// ===== rtl/core/mmsi_pkg.sv =====
// ----------------------------------------------------------------------------
// mmsi_pkg
// shared constants, codes and types of the multiproof sibling indexer
// ----------------------------------------------------------------------------
package mmsi_pkg;

  localparam int QUERY_W     = 16;
  localparam int NODE_W      = 17;
  localparam int LOG2_W      = 5;
  localparam int STATUS_W    = 3;
  localparam int MAX_QUERIES = 4;
  localparam int TREE_LEVELS = 16;
  localparam int FIFO_DEPTH  = MAX_QUERIES + 1;
  localparam int PTR_W       = $clog2(FIFO_DEPTH);
  localparam int CNT_W       = $clog2(FIFO_DEPTH + 1);
  localparam int MAX_RESULTS = 64;
  localparam int EMIT_W      = $clog2(MAX_RESULTS + 1);
  localparam int GUARD_STEP  = 65;
  localparam int GUARD_W     = $clog2(MAX_QUERIES * GUARD_STEP + 2);

  typedef logic [STATUS_W-1:0] status_t;

  // status codes; sibling doubles as "no error"
  localparam status_t STAT_SIBLING = 3'd0;
  localparam status_t STAT_NONE    = 3'd1;
  localparam status_t STAT_RANGE   = 3'd2;
  localparam status_t STAT_ORDER   = 3'd3;
  localparam status_t STAT_COUNT   = 3'd4;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_START = 6'b000010,
    S_LOAD  = 6'b000100,
    S_STEP  = 6'b001000,
    S_CMP   = 6'b010000,
    S_FIN   = 6'b100000
  } state_t;

  typedef struct packed {
    logic              en;
    logic [PTR_W-1:0]  addr;
    logic [NODE_W-1:0] data;
  } ram_wr_t;

  typedef struct packed {
    logic             en;
    logic [PTR_W-1:0] addr;
  } ram_rd_t;

  // ring pointer arithmetic modulo the fifo depth
  function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] base,
                                               input logic [CNT_W-1:0] offs);
    logic [PTR_W+CNT_W-1:0] sum;
    sum = (PTR_W+CNT_W)'(base) + (PTR_W+CNT_W)'(offs);
    if (sum >= (PTR_W+CNT_W)'(FIFO_DEPTH)) begin
      sum = sum - (PTR_W+CNT_W)'(FIFO_DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

endpackage

// ===== rtl/core/mmsi_node_ram.sv =====
// ----------------------------------------------------------------------------
// mmsi_node_ram
// node ring storage, one write and one registered read port, write forwarding
// ----------------------------------------------------------------------------
module mmsi_node_ram (
  input  logic                        clk,
  input  mmsi_pkg::ram_wr_t           wr,
  input  mmsi_pkg::ram_rd_t           rd,
  output logic [mmsi_pkg::NODE_W-1:0] rd_data
);
  import mmsi_pkg::*;

  logic [NODE_W-1:0] mem [FIFO_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      if (wr.en && (wr.addr == rd.addr)) begin
        rd_data <= wr.data;
      end else begin
        rd_data <= mem[rd.addr];
      end
    end
  end

endmodule

// ===== rtl/core/merkle_multiproof_sibling_indexer_unit.sv =====
// ----------------------------------------------------------------------------
// merkle_multiproof_sibling_indexer_unit
// queries load one per cycle while idle; a batch with an error goes to S_FIN
// after the last query; else the walk runs S_START and S_LOAD, then S_STEP and S_CMP
// per step (a merge goes back via S_LOAD), waiting in S_CMP on a stalled result
// S_FIN registers the final result once the result register is free
// rst_n is synchronous: clears control state, the node ring is not cleared
// ----------------------------------------------------------------------------
module merkle_multiproof_sibling_indexer_unit (
  input  logic        clk,
  input  logic        rst_n,
  // input items
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] query_index
  input  logic        in_tlast,   // last_query
  // result items
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [16:0] sibling_node, [23:17] zero
  output logic        out_tlast,  // final_result
  output logic [2:0]  out_tuser,  // [2:0] status
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import mmsi_pkg::*;

  state_t              state_r, state_nxt;
  logic [LOG2_W-1:0]   lg_r;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [PTR_W-1:0]    head_r, head_nxt;
  logic [QUERY_W-1:0]  prev_r, prev_nxt;
  logic                prev_valid_r, prev_valid_nxt;
  status_t             err_r, err_nxt;
  logic [NODE_W-1:0]   node_r, node_nxt;
  logic [NODE_W-1:0]   sib_r, sib_nxt;
  logic [GUARD_W-1:0]  guard_r, guard_nxt;
  logic [EMIT_W-1:0]   emit_cnt_r, emit_cnt_nxt;
  logic                pend_valid_r, pend_valid_nxt;
  logic [NODE_W-1:0]   pend_node_r, pend_node_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [NODE_W-1:0]   out_node_r, out_node_nxt;
  logic                out_final_r, out_final_nxt;
  status_t             out_status_r, out_status_nxt;

  ram_wr_t             wr;
  ram_rd_t             rd;
  logic [NODE_W-1:0]   rd_data;

  logic                in_acc;
  logic                out_free;
  logic                cfg_wr;
  logic [LOG2_W-1:0]   lg_eff;
  logic [NODE_W-1:0]   leaves;
  logic [QUERY_W-1:0]  query;

  mmsi_node_ram u_ram (
    .clk     (clk),
    .wr      (wr),
    .rd      (rd),
    .rd_data (rd_data)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign query      = in_tdata[QUERY_W-1:0];
  assign lg_eff     = (lg_r > LOG2_W'(TREE_LEVELS)) ? LOG2_W'(TREE_LEVELS) : lg_r;
  assign leaves     = NODE_W'(1) << lg_eff;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(24-NODE_W){1'b0}}, out_node_r};
  assign out_tlast  = out_final_r;
  assign out_tuser  = out_status_r;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && !cfg_paddr[2];
  assign cfg_prdata = cfg_paddr[2] ? 32'd0 : 32'(lg_r);

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    head_nxt       = head_r;
    prev_nxt       = prev_r;
    prev_valid_nxt = prev_valid_r;
    err_nxt        = err_r;
    node_nxt       = node_r;
    sib_nxt        = sib_r;
    guard_nxt      = guard_r;
    emit_cnt_nxt   = emit_cnt_r;
    pend_valid_nxt = pend_valid_r;
    pend_node_nxt  = pend_node_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_node_nxt   = out_node_r;
    out_final_nxt  = out_final_r;
    out_status_nxt = out_status_r;
    wr             = '0;
    rd             = '0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (err_r == STAT_SIBLING) begin
            if ({1'b0, query} >= leaves) begin
              err_nxt = STAT_RANGE;
            end else if (prev_valid_r && (query <= prev_r)) begin
              err_nxt = STAT_ORDER;
            end else if (cnt_r >= CNT_W'(MAX_QUERIES)) begin
              err_nxt = STAT_COUNT;
            end else begin
              wr.en          = 1'b1;
              wr.addr        = cnt_r[PTR_W-1:0];
              wr.data        = {1'b0, query} + leaves;
              cnt_nxt        = cnt_r + CNT_W'(1);
              prev_nxt       = query;
              prev_valid_nxt = 1'b1;
            end
          end
          if (in_tlast) begin
            if ((err_nxt != STAT_SIBLING) || (cnt_nxt == '0)) begin
              state_nxt = S_FIN;
            end else begin
              head_nxt  = '0;
              guard_nxt = GUARD_W'(cnt_nxt) * GUARD_W'(GUARD_STEP) + GUARD_W'(1);
              state_nxt = S_START;
            end
          end
        end
      end
      S_START: begin
        rd.en     = 1'b1;
        rd.addr   = head_r;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        node_nxt  = rd_data;
        state_nxt = S_STEP;
      end
      S_STEP: begin
        if ((node_r == NODE_W'(1)) || (node_r == '0) || (guard_r == '0)) begin
          state_nxt = S_FIN;
        end else begin
          guard_nxt = guard_r - GUARD_W'(1);
          // pop the head, push the parent at the tail
          head_nxt  = ptr_add(head_r, CNT_W'(1));
          wr.en     = 1'b1;
          wr.addr   = ptr_add(head_r, cnt_r);
          wr.data   = node_r >> 1;
          rd.en     = 1'b1;
          rd.addr   = head_nxt;
          sib_nxt   = node_r ^ NODE_W'(1);
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        if (rd_data == sib_r) begin
          // sibling already on a path
          head_nxt = ptr_add(head_r, CNT_W'(1));
          cnt_nxt  = cnt_r - CNT_W'(1);
          if (cnt_nxt == '0) begin
            state_nxt = S_FIN;
          end else begin
            rd.en     = 1'b1;
            rd.addr   = head_nxt;
            state_nxt = S_LOAD;
          end
        end else if (emit_cnt_r < EMIT_W'(MAX_RESULTS)) begin
          if (!pend_valid_r || out_free) begin
            if (pend_valid_r) begin
              out_valid_nxt  = 1'b1;
              out_node_nxt   = pend_node_r;
              out_final_nxt  = 1'b0;
              out_status_nxt = STAT_SIBLING;
            end
            pend_valid_nxt = 1'b1;
            pend_node_nxt  = sib_r;
            emit_cnt_nxt   = emit_cnt_r + EMIT_W'(1);
            node_nxt       = rd_data;
            state_nxt      = S_STEP;
          end
        end else begin
          node_nxt  = rd_data;
          state_nxt = S_STEP;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_final_nxt = 1'b1;
          if (err_r != STAT_SIBLING) begin
            out_node_nxt   = '0;
            out_status_nxt = err_r;
          end else if (pend_valid_r) begin
            out_node_nxt   = pend_node_r;
            out_status_nxt = STAT_SIBLING;
          end else begin
            out_node_nxt   = '0;
            out_status_nxt = STAT_NONE;
          end
          cnt_nxt        = '0;
          prev_valid_nxt = 1'b0;
          err_nxt        = STAT_SIBLING;
          pend_valid_nxt = 1'b0;
          emit_cnt_nxt   = '0;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      lg_r         <= '0;
      cnt_r        <= '0;
      head_r       <= '0;
      prev_valid_r <= 1'b0;
      err_r        <= STAT_SIBLING;
      guard_r      <= '0;
      emit_cnt_r   <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      if (cfg_wr) begin
        lg_r <= cfg_pwdata[LOG2_W-1:0];
      end
      cnt_r        <= cnt_nxt;
      head_r       <= head_nxt;
      prev_valid_r <= prev_valid_nxt;
      err_r        <= err_nxt;
      guard_r      <= guard_nxt;
      emit_cnt_r   <= emit_cnt_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prev_r       <= prev_nxt;
    node_r       <= node_nxt;
    sib_r        <= sib_nxt;
    pend_node_r  <= pend_node_nxt;
    out_node_r   <= out_node_nxt;
    out_final_r  <= out_final_nxt;
    out_status_r <= out_status_nxt;
  end

endmodule

// ===== rtl/core/mmsi_checker.sv =====
// ----------------------------------------------------------------------------
// mmsi_checker
// port-level checks of the multiproof sibling indexer
// ----------------------------------------------------------------------------
module mmsi_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tlast,
  input logic [2:0]  out_tuser
);
  import mmsi_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tlast) && $stable(out_tuser))
    else $error("result item changed while stalled");

  // any status other than sibling ends the batch with node zero
  a_status_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != STAT_SIBLING) |-> out_tlast && (out_tdata == '0))
    else $error("non-sibling status without final mark");

  // results before the final one are real siblings
  a_mid_sibling: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> (out_tuser == STAT_SIBLING) && (out_tdata != '0))
    else $error("intermediate result is not a sibling");

  // the last query starts the walk or the final result, no new query is taken right after it
  a_walk_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready)
    else $error("query taken right after the last query");

endmodule

bind merkle_multiproof_sibling_indexer_unit mmsi_checker u_mmsi_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);
